[hdl/lcpt_pkg.sv]
// Shared types, constants and lookup tables for the lores cell pair to TMDS renderer.
package lcpt_pkg;

    localparam int SYM_W           = 20;
    localparam int BYTE_W          = 8;
    localparam int NIB_W           = 4;
    localparam int DOT_W           = 14;
    localparam int WORD_W          = 32;
    localparam int CFG_IDX_W       = 3;
    localparam int RESULTS_PER_PAIR = 14;
    localparam int STEP_W          = 4;
    localparam int REPEAT_PER_CELL = 7;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(RESULTS_PER_PAIR - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MONO_MODE     = 3'd0,
        CFG_SYM_OFF_OFF   = 3'd1,
        CFG_SYM_OFF_ON    = 3'd2,
        CFG_SYM_ON_OFF    = 3'd3,
        CFG_SYM_ON_ON     = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [SYM_W-1:0] red;
        logic [SYM_W-1:0] green;
        logic [SYM_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [SYM_W-1:0] off_off;
        logic [SYM_W-1:0] off_on;
        logic [SYM_W-1:0] on_off;
        logic [SYM_W-1:0] on_on;
    } sym_set_t;

    typedef struct packed {
        logic load;
        logic last;
    } out_ctrl_t;

    // 14-dot pattern of one mono nibble
    function automatic logic [DOT_W-1:0] dot_pattern(input logic [NIB_W-1:0] nib);
        logic [DOT_W-1:0] d;
        begin
            unique case (nib)
                4'h0: d = 14'h0000;
                4'h1: d = 14'h2222;
                4'h2: d = 14'h1111;
                4'h3: d = 14'h3333;
                4'h4: d = 14'h0888;
                4'h5: d = 14'h2AAA;
                4'h6: d = 14'h1999;
                4'h7: d = 14'h3BBB;
                4'h8: d = 14'h0444;
                4'h9: d = 14'h2666;
                4'hA: d = 14'h1555;
                4'hB: d = 14'h3777;
                4'hC: d = 14'h0CCC;
                4'hD: d = 14'h2EEE;
                4'hE: d = 14'h1DDD;
                default: d = 14'h3FFF;
            endcase
            return d;
        end
    endfunction

    // fixed RGB pair symbols of the sixteen colours
    function automatic rgb_t colour_symbols(input logic [NIB_W-1:0] nib);
        rgb_t c;
        begin
            unique case (nib)
                4'h0: c = '{20'h7fd00, 20'h7fd00, 20'h7fd00};
                4'h1: c = '{20'h8fec0, 20'h425f6, 20'h906be};
                4'h2: c = '{20'h4f1c3, 20'h7911b, 20'hbfe00};
                4'h3: c = '{20'h802ff, 20'h4f9c1, 20'hbfe00};
                4'h4: c = '{20'h7fd00, 20'h6017f, 20'h906be};
                4'h5: c = '{20'h5fd80, 20'h5fd80, 20'h5fd80};
                4'h6: c = '{20'hae247, 20'hb7a21, 20'hbfe00};
                4'h7: c = '{20'h6f941, 20'h882df, 20'hbfe00};
                4'h8: c = '{20'h902bf, 20'ha3273, 20'h7fd00};
                4'h9: c = '{20'hbfa01, 20'h9c28f, 20'h7fd00};
                4'hA: c = '{20'h5fd80, 20'h5fd80, 20'h5fd80};
                4'hB: c = '{20'hbfe00, 20'h5f582, 20'h501bf};
                4'hC: c = '{20'haf243, 20'h83af1, 20'h7fd00};
                4'hD: c = '{20'h505be, 20'hbce0c, 20'h7fd00};
                4'hE: c = '{20'h99e98, 20'hbfe00, 20'h6fd40};
                default: c = '{20'hbfe00, 20'hbfe00, 20'hbfe00};
            endcase
            return c;
        end
    endfunction

endpackage

[hdl/lores_cell_pair_to_tmds.sv]
// Top level of the lores cell pair to TMDS renderer.
//
// Input channel (in_valid/in_ready) takes one beat of two adjacent lores
// screen bytes. Each input beat produces fourteen output beats
// (out_valid/out_ready), each carrying a red/green/blue pair symbol for the
// upper row (low nibbles) and the lower row (high nibbles); last_of_pair marks
// the fourteenth. Two lanes, one per row, build their symbols side by side and
// the output register merges them into one beat.
// Each input beat is registered when taken, and every result passes through
// the output register. Throughput: one output beat per cycle unless the
// receiver stalls; the step counter of the current pair holds off the next
// input beat. The next pair is taken in the same cycle that the fourteenth
// result enters the output register, so pairs stream with no gap.
// Configuration: cfg_write/cfg_index/cfg_data write mono_mode (0) and the four
// mono pair symbols (1..4); write only while no pair is in flight.
// Reset clears configuration, the step counter and the output valid.
// When the receiver stalls, the output register holds its beat and the step
// counter stops; in_ready stays low until the last result of the pair moves.
module lores_cell_pair_to_tmds #(
    parameter int REPEAT_PER_CELL = lcpt_pkg::REPEAT_PER_CELL
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [lcpt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lcpt_pkg::SYM_W-1:0]         cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [lcpt_pkg::BYTE_W-1:0]        first_byte,
    input  logic [lcpt_pkg::BYTE_W-1:0]        second_byte,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [lcpt_pkg::SYM_W-1:0]         upper_red,
    output logic [lcpt_pkg::SYM_W-1:0]         upper_green,
    output logic [lcpt_pkg::SYM_W-1:0]         upper_blue,
    output logic [lcpt_pkg::SYM_W-1:0]         lower_red,
    output logic [lcpt_pkg::SYM_W-1:0]         lower_green,
    output logic [lcpt_pkg::SYM_W-1:0]         lower_blue,
    output logic                               last_of_pair
);

    logic                           mono_reg;
    lcpt_pkg::sym_set_t             syms_reg;
    logic                           busy_reg;
    logic                           busy_next;
    logic [lcpt_pkg::STEP_W-1:0]    step_reg;
    logic [lcpt_pkg::STEP_W-1:0]    step_next;
    logic [lcpt_pkg::BYTE_W-1:0]    first_reg;
    logic [lcpt_pkg::BYTE_W-1:0]    second_reg;
    logic                           space;
    logic                           at_last;
    logic                           take;
    logic                           advance;
    lcpt_pkg::out_ctrl_t            ctrl;
    lcpt_pkg::rgb_t                 upper_rgb;
    lcpt_pkg::rgb_t                 lower_rgb;
    lcpt_pkg::rgb_t                 upper_q;
    lcpt_pkg::rgb_t                 lower_q;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mono_reg <= 1'b0;
            syms_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (lcpt_pkg::cfg_index_t'(cfg_index))
                lcpt_pkg::CFG_MONO_MODE:   mono_reg         <= cfg_data[0];
                lcpt_pkg::CFG_SYM_OFF_OFF: syms_reg.off_off <= cfg_data;
                lcpt_pkg::CFG_SYM_OFF_ON:  syms_reg.off_on  <= cfg_data;
                lcpt_pkg::CFG_SYM_ON_OFF:  syms_reg.on_off  <= cfg_data;
                lcpt_pkg::CFG_SYM_ON_ON:   syms_reg.on_on   <= cfg_data;
                default:                   mono_reg         <= mono_reg;
            endcase
        end
    end

    // step sequencer
    assign at_last  = step_reg == lcpt_pkg::STEP_LAST;
    assign advance  = busy_reg && space;
    assign in_ready = !busy_reg || (space && at_last);
    assign take     = in_valid && in_ready;

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (advance)
        begin
            step_next = at_last ? '0 : step_reg + 1'b1;
            if (at_last)
            begin
                busy_next = 1'b0;
            end
        end
        if (take)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            first_reg  <= first_byte;
            second_reg <= second_byte;
        end
    end

    lcpt_lane #(
        .REPEAT_PER_CELL (REPEAT_PER_CELL)
    ) u_upper_lane (
        .first_nib  (first_reg[lcpt_pkg::NIB_W-1:0]),
        .second_nib (second_reg[lcpt_pkg::NIB_W-1:0]),
        .step       (step_reg),
        .mono       (mono_reg),
        .syms       (syms_reg),
        .rgb        (upper_rgb)
    );

    lcpt_lane #(
        .REPEAT_PER_CELL (REPEAT_PER_CELL)
    ) u_lower_lane (
        .first_nib  (first_reg[lcpt_pkg::BYTE_W-1:lcpt_pkg::NIB_W]),
        .second_nib (second_reg[lcpt_pkg::BYTE_W-1:lcpt_pkg::NIB_W]),
        .step       (step_reg),
        .mono       (mono_reg),
        .syms       (syms_reg),
        .rgb        (lower_rgb)
    );

    assign ctrl.load = busy_reg;
    assign ctrl.last = at_last;

    lcpt_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .upper_in  (upper_rgb),
        .lower_in  (lower_rgb),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .upper_out (upper_q),
        .lower_out (lower_q),
        .last_out  (last_of_pair)
    );

    assign upper_red   = upper_q.red;
    assign upper_green = upper_q.green;
    assign upper_blue  = upper_q.blue;
    assign lower_red   = lower_q.red;
    assign lower_green = lower_q.green;
    assign lower_blue  = lower_q.blue;

endmodule

[hdl/lcpt_lane.sv]
// One row lane: symbol triple of one pixel pair for a given step of the cell pair.
module lcpt_lane #(
    parameter int REPEAT_PER_CELL = lcpt_pkg::REPEAT_PER_CELL
) (
    input  logic [lcpt_pkg::NIB_W-1:0]  first_nib,
    input  logic [lcpt_pkg::NIB_W-1:0]  second_nib,
    input  logic [lcpt_pkg::STEP_W-1:0] step,
    input  logic                        mono,
    input  lcpt_pkg::sym_set_t          syms,
    output lcpt_pkg::rgb_t              rgb
);

    logic [lcpt_pkg::WORD_W-1:0] dot_word;
    logic [4:0]                  pair_pos;
    logic [1:0]                  dot_pair;
    logic                        use_first;
    logic [lcpt_pkg::NIB_W-1:0]  cell_nib;
    logic [lcpt_pkg::SYM_W-1:0]  green_sym;

    // first << 14 | second; bits 31..28 stay dark
    assign dot_word = {4'b0000, lcpt_pkg::dot_pattern(first_nib),
                       lcpt_pkg::dot_pattern(second_nib)};

    // step k reads the dot pair at bits 31-2k and 30-2k
    assign pair_pos = 5'(30) - {step, 1'b0};
    assign dot_pair = dot_word[pair_pos +: 2];

    assign use_first = {1'b0, step} < 5'(REPEAT_PER_CELL);
    assign cell_nib  = use_first ? first_nib : second_nib;

    always_comb
    begin
        unique case (dot_pair)
            2'b00:   green_sym = syms.off_off;
            2'b01:   green_sym = syms.off_on;
            2'b10:   green_sym = syms.on_off;
            default: green_sym = syms.on_on;
        endcase
    end

    always_comb
    begin
        if (mono)
        begin
            rgb.red   = syms.off_off;
            rgb.green = green_sym;
            rgb.blue  = syms.off_off;
        end
        else
        begin
            rgb = lcpt_pkg::colour_symbols(cell_nib);
        end
    end

endmodule

[hdl/lcpt_out_stage.sv]
// Output register that merges the upper and lower lane results into one beat.
module lcpt_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lcpt_pkg::out_ctrl_t  ctrl,
    input  lcpt_pkg::rgb_t       upper_in,
    input  lcpt_pkg::rgb_t       lower_in,
    output logic                 space,
    output logic                 out_valid,
    input  logic                 out_ready,
    output lcpt_pkg::rgb_t       upper_out,
    output lcpt_pkg::rgb_t       lower_out,
    output logic                 last_out
);

    logic           valid_reg;
    logic           valid_next;
    logic           last_reg;
    lcpt_pkg::rgb_t upper_reg;
    lcpt_pkg::rgb_t lower_reg;

    // register is free when empty or being drained this cycle
    assign space = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (space)
        begin
            valid_next = ctrl.load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (space && ctrl.load)
            begin
                last_reg <= ctrl.last;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (space && ctrl.load)
        begin
            upper_reg <= upper_in;
            lower_reg <= lower_in;
        end
    end

    assign out_valid = valid_reg;
    assign upper_out = upper_reg;
    assign lower_out = lower_reg;
    assign last_out  = last_reg;

endmodule

[hdl/lcpt_checker.sv]
// Port-level checks for the lores cell pair to TMDS renderer, bound to the top level.
module lcpt_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic [lcpt_pkg::BYTE_W-1:0]        first_byte,
    input  logic [lcpt_pkg::BYTE_W-1:0]        second_byte,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic [lcpt_pkg::SYM_W-1:0]         upper_red,
    input  logic [lcpt_pkg::SYM_W-1:0]         upper_green,
    input  logic [lcpt_pkg::SYM_W-1:0]         upper_blue,
    input  logic [lcpt_pkg::SYM_W-1:0]         lower_red,
    input  logic [lcpt_pkg::SYM_W-1:0]         lower_green,
    input  logic [lcpt_pkg::SYM_W-1:0]         lower_blue,
    input  logic                               last_of_pair
);

    // hold a stalled output beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(upper_red) && $stable(upper_green)
            && $stable(upper_blue) && $stable(lower_red) && $stable(lower_green)
            && $stable(lower_blue) && $stable(last_of_pair))
        else $error("output beat changed while stalled");

    // hold a waiting input beat
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(first_byte) && $stable(second_byte))
        else $error("input beat changed while waiting");

    // a new pair blocks the input for its first result at least
    a_in_block: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after taking a pair");

    // results of one pair follow back to back
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_pair |=> out_valid)
        else $error("gap inside a pair of results");

    // leave reset with nothing on the output
    a_reset_clean: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("output valid straight out of reset");

endmodule

bind lores_cell_pair_to_tmds lcpt_checker u_lcpt_checker (.*);
